/* hdl/vbp_pkg.sv */
// Shared widths and constants for the variable-width bit packer.
package vbp_pkg;

    // Payload widths of the field and word channels
    localparam int VALUE_W = 63;
    localparam int WIDTH_W = 6;
    localparam int WORD_W  = 64;

    // Fill count and the shift amount used to pick a word out of the hull
    localparam int CNT_W   = 6;
    localparam int SUM_W   = CNT_W + 1;
    localparam int HULL_W  = 2 * WORD_W;
    localparam int STAGE_W = HULL_W + WORD_W;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [HULL_W-1:0]  hull_t;
    typedef logic [CNT_W-1:0]   count_t;
    typedef logic [SUM_W-1:0]   sum_t;

endpackage

/* hdl/vbp_field_if.sv */
// Handshake channel that carries one field item (value and width).
interface vbp_field_if import vbp_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] field_value;
    logic [WIDTH_W-1:0] field_width;

    modport source (output valid, output field_value, output field_width, input ready);
    modport sink   (input valid, input field_value, input field_width, output ready);

endinterface

/* hdl/vbp_word_if.sv */
// Handshake channel that carries one packed 64-bit word item.
interface vbp_word_if import vbp_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] packed_word;

    modport source (output valid, output packed_word, input ready);
    modport sink   (input valid, input packed_word, output ready);

endinterface

/* hdl/variable_width_bit_packer.sv */
// Top level of the variable-width bit packer: input register, hull update, word register.
//
//  Channel   Direction  Payload                         Item accepted when
//  fields    in         field_value[62:0], field_width  fields.valid && fields.ready
//  words     out        packed_word[63:0]               words.valid && words.ready
//
// One field item is taken every cycle unless a stalled word holds it back.
// The pace is set by the single update stage: a 192-bit right shift of the hull
// followed by the 128-bit shift that picks the finished word out of it.
// rst_n clears the hull, the fill count and both valid flags at once.
// A stalled word only holds back an item that would itself finish a word;
// items that finish no word keep flowing while the word waits.
module variable_width_bit_packer import vbp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    vbp_field_if.sink fields,
    vbp_word_if.source words
);

    // Input register
    logic               in_valid_reg;
    logic [VALUE_W-1:0] in_value_reg;
    logic [WIDTH_W-1:0] in_width_reg;

    // Packer state
    word_t  hull_high_reg;
    word_t  hull_low_reg;
    count_t fill_count_reg;
    word_t  hull_high_next;
    word_t  hull_low_next;
    count_t fill_count_next;

    // Result register
    logic   out_valid_reg;
    word_t  out_word_reg;
    word_t  out_word_next;

    // Datapath intermediates
    sum_t                 fill_sum;
    logic                 word_done;
    logic [STAGE_W-1:0]   shifted;
    hull_t                hull_new;
    logic [SUM_W-1:0]     pick_shift;
    hull_t                picked;
    logic                 out_free;
    logic                 advance;

    // Fill count advance; a carry out of six bits means a full word is ready
    assign fill_sum  = {1'b0, fill_count_reg} + SUM_W'(in_width_reg);
    assign word_done = fill_sum[CNT_W];
    assign fill_count_next = fill_sum[CNT_W-1:0];

    // Shift the hull right by the width; the field's low bits enter at the top
    assign shifted  = {WORD_W'(in_value_reg), hull_high_reg, hull_low_reg} >> in_width_reg;
    assign hull_new = shifted[HULL_W-1:0];
    assign hull_high_next = hull_new[HULL_W-1:WORD_W];
    assign hull_low_next  = hull_new[WORD_W-1:0];

    // The finished word starts 64 minus the new count bits up the hull
    assign pick_shift    = SUM_W'(WORD_W) - {1'b0, fill_count_next};
    assign picked        = hull_new >> pick_shift;
    assign out_word_next = picked[WORD_W-1:0];

    // Flow control: only an item that finishes a word waits for the result register
    assign out_free     = !out_valid_reg || words.ready;
    assign advance      = in_valid_reg && (!word_done || out_free);
    assign fields.ready = !in_valid_reg || advance;

    assign words.valid       = out_valid_reg;
    assign words.packed_word = out_word_reg;

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (fields.ready)
        begin
            in_valid_reg <= fields.valid;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (fields.valid && fields.ready)
        begin
            in_value_reg <= fields.field_value;
            in_width_reg <= fields.field_width;
        end
    end

    // Hull and fill count; a zero width leaves both unchanged by construction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hull_high_reg  <= '0;
            hull_low_reg   <= '0;
            fill_count_reg <= '0;
        end
        else if (advance)
        begin
            hull_high_reg  <= hull_high_next;
            hull_low_reg   <= hull_low_next;
            fill_count_reg <= fill_count_next;
        end
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && word_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (words.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (advance && word_done)
        begin
            out_word_reg <= out_word_next;
        end
    end

endmodule

/* hdl/vbp_checker.sv */
// Port-level assertions for the variable-width bit packer and their bind.
module vbp_checker import vbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    vbp_field_if.sink  fields,
    vbp_word_if.source words
);

    // A waiting word stays offered until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        words.valid && !words.ready |=> words.valid)
    else $error("word item dropped while stalled");

    // A waiting word keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        words.valid && !words.ready |=> $stable(words.packed_word))
    else $error("word item changed while stalled");

    // Field items are refused only while a finished word is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !fields.ready |-> words.valid && !words.ready)
    else $error("field item refused without a stalled word");

    // No word is offered in reset or in the first cycle after it
    assert property (@(posedge clk)
        !rst_n || $past(!rst_n) |-> !words.valid)
    else $error("word item offered out of reset");

endmodule

bind variable_width_bit_packer vbp_checker u_vbp_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .fields (fields),
    .words  (words)
);

/* sim/vbp_word_checker.sv */
// Checker for the bit packer: predicts packed words from accepted fields and compares them.
`timescale 1ns / 1ps

module vbp_word_checker import vbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    vbp_field_if        fields,
    vbp_word_if         words,
    output int unsigned error_count,
    output int unsigned words_pending,
    output int unsigned fields_packed,
    output int unsigned fields_ignored,
    output int unsigned words_matched
);

    // Private copy of the packer state.
    word_t  hull_hi;
    word_t  hull_lo;
    count_t fill;

    // Words that the accepted fields have finished but that have not come out yet.
    word_t  expected_words[$];

    // Shift one field into the hull; report the word it finishes, if any.
    function automatic void advance_hull(input logic [VALUE_W-1:0] value,
                                         input logic [WIDTH_W-1:0] width,
                                         output logic              finished,
                                         output word_t             word);
        int   rest;
        sum_t total;
        word_t wide_value;
        word_t low_part;

        finished   = 1'b0;
        word       = '0;
        rest       = WORD_W - int'(width);
        wide_value = word_t'(value);
        hull_lo    = (hull_lo >> width) | (hull_hi << rest);
        hull_hi    = (hull_hi >> width) | (wide_value << rest);
        total      = sum_t'(fill) + sum_t'(width);
        fill       = total[CNT_W-1:0];
        if (total[CNT_W])
        begin
            // With an empty remainder the word is the whole upper half.
            low_part = (fill == '0) ? '0 : (hull_lo >> (WORD_W - int'(fill)));
            word     = low_part | (hull_hi << fill);
            finished = 1'b1;
        end
    endfunction

    // Watch both channels at every rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        logic  finished;
        word_t word;
        word_t want;

        if (!rst_n)
        begin
            hull_hi        <= '0;
            hull_lo        <= '0;
            fill           <= '0;
            error_count    <= 0;
            fields_packed  <= 0;
            fields_ignored <= 0;
            words_matched  <= 0;
            expected_words.delete();
            words_pending  <= 0;
        end
        else
        begin
            // A zero-width field leaves the state alone.
            if (fields.valid && fields.ready)
            begin
                if (fields.field_width == '0)
                begin
                    fields_ignored <= fields_ignored + 1;
                end
                else
                begin
                    advance_hull(fields.field_value, fields.field_width, finished, word);
                    if (finished)
                    begin
                        expected_words.push_back(word);
                    end
                    fields_packed <= fields_packed + 1;
                end
            end

            // Each word item must match the oldest outstanding prediction.
            if (words.valid && words.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("packed_word: no word expected, actual %h", words.packed_word);
                    error_count <= error_count + 1;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (words.packed_word !== want)
                    begin
                        $error("packed_word mismatch: expected %h, actual %h",
                               want, words.packed_word);
                        error_count <= error_count + 1;
                    end
                    else
                    begin
                        words_matched <= words_matched + 1;
                    end
                end
            end
            words_pending <= expected_words.size();
        end
    end

endmodule

/* sim/variable_width_bit_packer_tb.sv */
// Testbench top for the variable-width bit packer: clock, reset, field stimulus and verdict.
`timescale 1ns / 1ps

module variable_width_bit_packer_tb import vbp_pkg::*;;

    localparam int          RANDOM_FIELDS = 1800;
    localparam int          DRAIN_CYCLES  = 10;
    localparam int unsigned CYCLE_LIMIT   = 400000;

    logic clk = 1'b0;
    logic rst_n;

    int unsigned error_count;
    int unsigned words_pending;
    int unsigned fields_packed;
    int unsigned fields_ignored;
    int unsigned words_matched;
    int unsigned cycle_count = 0;

    vbp_field_if fields ();
    vbp_word_if  words ();

    variable_width_bit_packer dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fields (fields),
        .words  (words)
    );

    vbp_word_checker checker_i
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .fields         (fields),
        .words          (words),
        .error_count    (error_count),
        .words_pending  (words_pending),
        .fields_packed  (fields_packed),
        .fields_ignored (fields_ignored),
        .words_matched  (words_matched)
    );

    // Free-running clock, 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("variable_width_bit_packer_tb: errors");
            $finish;
        end
    end

    // Word receiver: stretches of steady readiness, random stalls and long holds.
    initial
    begin
        int stall_mode;
        int stretch;

        words.ready = 1'b0;
        stall_mode  = 0;
        stretch     = 0;
        forever
        begin
            @(posedge clk);
            if (stretch == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stretch    = $urandom_range(5, 60);
            end
            stretch = stretch - 1;
            case (stall_mode)
                0:       words.ready <= 1'b1;
                1:       words.ready <= ($urandom_range(0, 1) == 1);
                2:       words.ready <= ($urandom_range(0, 7) != 0);
                default: words.ready <= (stretch % 20 == 0);
            endcase
        end
    end

    // Offer one field and hold it until the packer takes it.
    task automatic send_field(input logic [VALUE_W-1:0] value, input logic [WIDTH_W-1:0] width);
        fields.valid       <= 1'b1;
        fields.field_value <= value;
        fields.field_width <= width;
        do
        begin
            @(posedge clk);
        end
        while (!fields.ready);
    endtask

    // Pause the sender for a number of cycles with valid low.
    task automatic idle_sender(input int cycles);
        fields.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Reset, directed fields, random bursts, drain and verdict.
    initial
    begin
        logic [VALUE_W-1:0] ones;
        logic [VALUE_W-1:0] value;
        logic [WIDTH_W-1:0] width;
        int                 pick;
        int                 burst_left;
        int                 packed_random;

        ones               = '1;
        rst_n              = 1'b0;
        fields.valid       = 1'b0;
        fields.field_value = '0;
        fields.field_width = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Excess value bits must be dropped; two half words land exactly on a word boundary.
        send_field(ones, 6'd32);
        send_field(63'h5555_5555_5555_5555, 6'd32);
        // A zero-width field is ignored.
        send_field(ones, 6'd0);
        // Widest and narrowest fields, crossing the boundary in both directions.
        send_field(ones, 6'd63);
        send_field('0, 6'd1);
        send_field(63'h1, 6'd1);
        send_field(63'h2AAA_AAAA_AAAA_AAAA, 6'd63);
        send_field('0, 6'd63);
        send_field(ones, 6'd63);
        send_field(ones, 6'd2);
        send_field('0, 6'd0);
        idle_sender(3);
        // Ten single bits and a 54-bit field fill a word, with idle gaps before and after.
        for (int i = 0; i < 10; i++)
        begin
            send_field(ones ^ VALUE_W'(i & 1), 6'd1);
        end
        send_field(63'h0123_4567_89AB_CDEF, 6'd54);
        send_field(ones, 6'd31);
        idle_sender(2);

        // Random fields in bursts; narrow and near-full widths are favored.
        packed_random = 0;
        burst_left    = $urandom_range(1, 40);
        while (packed_random < RANDOM_FIELDS)
        begin
            value = VALUE_W'({$urandom, $urandom});
            pick  = $urandom_range(0, 99);
            if (pick < 2)
            begin
                width = '0;
            end
            else if (pick < 17)
            begin
                width = WIDTH_W'($urandom_range(1, 4));
            end
            else if (pick < 30)
            begin
                width = WIDTH_W'($urandom_range(60, 63));
            end
            else
            begin
                width = WIDTH_W'($urandom_range(1, 63));
            end
            send_field(value, width);
            if (width != '0)
            begin
                packed_random = packed_random + 1;
            end
            if (burst_left == 0)
            begin
                idle_sender($urandom_range(1, 8));
                // Now and then a long burst with no idling at all.
                burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                                                         : $urandom_range(1, 40);
            end
            else
            begin
                burst_left = burst_left - 1;
            end
        end
        fields.valid <= 1'b0;

        // Drain outstanding words; the pending count is registered, so it lags the last field.
        do
        begin
            @(posedge clk);
        end
        while (words_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (words_pending != 0)
        begin
            $error("packed_word: %0d expected words never arrived", words_pending);
        end
        $display("Packed %0d fields (%0d zero-width fields ignored) into %0d checked words,",
                 fields_packed, fields_ignored, words_matched);
        $display("with random sender gaps and receiver stalls over %0d cycles.", cycle_count);
        if (error_count == 0 && words_pending == 0)
        begin
            $display("variable_width_bit_packer_tb: clean");
        end
        else
        begin
            $display("variable_width_bit_packer_tb: errors");
        end
        $finish;
    end

endmodule
